// File: hdl/tgarle_pkg.sv
// Shared types and constants for the TGA run-length packet decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package tgarle_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PIXEL_W = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned BPP_W   = 3;
    localparam int unsigned IDX_W   = 2;

    localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd3;
    localparam logic [BPP_W-1:0]   BPP_MIN     = 3'd1;
    localparam logic [BPP_W-1:0]   BPP_MAX     = 3'd4;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 32'd1;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 32'd1;
    localparam logic               RELAX_RESET = 1'b1;
    localparam logic [BYTE_W-1:0]  REPEAT_BIAS = 8'd127;

    typedef enum logic [IDX_W-1:0] {
        CFG_BPP   = 2'd0,
        CFG_COUNT = 2'd1,
        CFG_RELAX = 2'd2
    } cfg_idx_t;

    // Effective configuration seen by the decode core
    typedef struct packed {
        logic [BPP_W-1:0]   bpp;
        logic [COUNT_W-1:0] count;
        logic               relax;
        logic               restart;
    } cfg_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_value;
        logic [7:0]         run_length;
        logic               image_end;
        logic               overrun_error;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/tgarle_cfg_regs.sv
// Configuration registers of the TGA RLE decoder: write port and effective values.
// Depends on tgarle_pkg.
`default_nettype none

module tgarle_cfg_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [tgarle_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                  cfg_data,
    output tgarle_pkg::cfg_t                  cfg
);

    logic [tgarle_pkg::BPP_W-1:0]   bpp_reg,   bpp_next;
    logic [tgarle_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                           relax_reg, relax_next;
    logic                           restart_reg, restart_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        bpp_next     = bpp_reg;
        count_next   = count_reg;
        relax_next   = relax_reg;
        restart_next = 1'b0;
        if (cfg_valid && cfg_ready) begin
            unique case (tgarle_pkg::cfg_idx_t'(cfg_index))
                tgarle_pkg::CFG_BPP: begin
                    bpp_next = cfg_data[tgarle_pkg::BPP_W-1:0];
                end
                tgarle_pkg::CFG_COUNT: begin
                    count_next   = cfg_data[tgarle_pkg::COUNT_W-1:0];
                    restart_next = 1'b1;
                end
                tgarle_pkg::CFG_RELAX: begin
                    relax_next = cfg_data[0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg     <= tgarle_pkg::BPP_RESET;
            count_reg   <= tgarle_pkg::COUNT_RESET;
            relax_reg   <= tgarle_pkg::RELAX_RESET;
            restart_reg <= 1'b0;
        end else begin
            bpp_reg     <= bpp_next;
            count_reg   <= count_next;
            relax_reg   <= relax_next;
            restart_reg <= restart_next;
        end
    end

    // Out-of-range widths saturate to 1..4, a zero count acts as one pixel
    always_comb begin
        if (bpp_reg < tgarle_pkg::BPP_MIN) begin
            cfg.bpp = tgarle_pkg::BPP_MIN;
        end else if (bpp_reg > tgarle_pkg::BPP_MAX) begin
            cfg.bpp = tgarle_pkg::BPP_MAX;
        end else begin
            cfg.bpp = bpp_reg;
        end
        cfg.count   = (count_reg == '0) ? tgarle_pkg::COUNT_MIN : count_reg;
        cfg.relax   = relax_reg;
        cfg.restart = restart_reg;
    end

endmodule

`default_nettype wire

// File: hdl/tgarle_decode_core.sv
// Input register, packet/pixel state and single-pass decode logic.
// Depends on tgarle_pkg; fed by tgarle_cfg_regs, drains into tgarle_out_reg.
`default_nettype none

module tgarle_decode_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [tgarle_pkg::BYTE_W-1:0] s_packet_byte,
    input  wire tgarle_pkg::cfg_t              cfg,
    input  wire logic                          advance,
    output logic                               res_valid,
    output tgarle_pkg::result_t                res
);

    logic                            in_valid_reg, in_valid_next;
    logic [tgarle_pkg::BYTE_W-1:0]   in_byte_reg;

    logic                            expect_header_reg, expect_header_next;
    logic                            repeat_reg, repeat_next;
    logic [1:0]                      byte_idx_reg, byte_idx_next;
    logic [7:0]                      pkt_left_reg, pkt_left_next;
    logic [tgarle_pkg::PIXEL_W-1:0]  assembly_reg, assembly_next;
    logic [tgarle_pkg::COUNT_W-1:0]  pix_left_reg, pix_left_next;

    logic                            fire;
    logic                            hdr_rep;
    logic [7:0]                      hdr_len;
    logic                            hdr_over;
    logic [tgarle_pkg::PIXEL_W-1:0]  asm_full;
    logic                            pixel_done;
    logic [7:0]                      run;
    logic [tgarle_pkg::COUNT_W-1:0]  run_wide;
    logic [tgarle_pkg::COUNT_W-1:0]  pix_left_sub;
    logic [7:0]                      pkt_left_sub;

    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_packet_byte;
        end
    end

    // Header decode: repeat length is byte-127, raw length is byte+1 (both 1..128)
    assign hdr_rep  = in_byte_reg[7];
    assign hdr_len  = hdr_rep ? (in_byte_reg - tgarle_pkg::REPEAT_BIAS) : (in_byte_reg + 8'd1);
    assign hdr_over = {24'd0, hdr_len} > pix_left_reg;

    // Pixel path
    assign asm_full   = assembly_reg
                      | ({24'd0, in_byte_reg} << {byte_idx_reg, 3'b000});
    assign pixel_done = ({1'b0, byte_idx_reg} + 3'd1) >= cfg.bpp;
    assign run        = repeat_reg ? pkt_left_reg : 8'd1;
    assign run_wide   = {24'd0, run};
    assign pix_left_sub = (pix_left_reg >= run_wide) ? (pix_left_reg - run_wide) : '0;
    assign pkt_left_sub = (pkt_left_reg >= run) ? (pkt_left_reg - run) : 8'd0;

    always_comb begin
        expect_header_next = expect_header_reg;
        repeat_next        = repeat_reg;
        byte_idx_next      = byte_idx_reg;
        pkt_left_next      = pkt_left_reg;
        assembly_next      = assembly_reg;
        pix_left_next      = pix_left_reg;
        res_valid          = 1'b0;
        res                = '0;

        if (cfg.restart) begin
            expect_header_next = 1'b1;
            repeat_next        = 1'b0;
            byte_idx_next      = 2'd0;
            pkt_left_next      = 8'd0;
            assembly_next      = '0;
            pix_left_next      = cfg.count;
        end else if (fire) begin
            if (expect_header_reg) begin
                if (hdr_over && !cfg.relax) begin
                    // strict overrun: error beat, image restarts
                    res_valid         = 1'b1;
                    res.image_end     = 1'b1;
                    res.overrun_error = 1'b1;
                    repeat_next       = 1'b0;
                    byte_idx_next     = 2'd0;
                    pkt_left_next     = 8'd0;
                    assembly_next     = '0;
                    pix_left_next     = cfg.count;
                end else begin
                    expect_header_next = 1'b0;
                    repeat_next        = hdr_rep;
                    pkt_left_next      = hdr_over ? pix_left_reg[7:0] : hdr_len;
                    byte_idx_next      = 2'd0;
                    assembly_next      = '0;
                end
            end else if (!pixel_done) begin
                assembly_next = asm_full;
                byte_idx_next = byte_idx_reg + 2'd1;
            end else begin
                res_valid       = 1'b1;
                res.pixel_value = asm_full;
                res.run_length  = run;
                res.image_end   = (pix_left_sub == '0);
                byte_idx_next   = 2'd0;
                assembly_next   = '0;
                pkt_left_next   = pkt_left_sub;
                pix_left_next   = pix_left_sub;
                if (pix_left_sub == '0) begin
                    expect_header_next = 1'b1;
                    repeat_next        = 1'b0;
                    pkt_left_next      = 8'd0;
                    pix_left_next      = cfg.count;
                end else if (pkt_left_sub == 8'd0) begin
                    expect_header_next = 1'b1;
                    repeat_next        = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_header_reg <= 1'b1;
            repeat_reg        <= 1'b0;
            byte_idx_reg      <= 2'd0;
            pkt_left_reg      <= 8'd0;
            assembly_reg      <= '0;
            pix_left_reg      <= tgarle_pkg::COUNT_RESET;
        end else begin
            expect_header_reg <= expect_header_next;
            repeat_reg        <= repeat_next;
            byte_idx_reg      <= byte_idx_next;
            pkt_left_reg      <= pkt_left_next;
            assembly_reg      <= assembly_next;
            pix_left_reg      <= pix_left_next;
        end
    end

`ifndef SYNTHESIS
    a_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_left_reg != '0)
        else $error("pixels left reached zero without reload");

    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.overrun_error |-> res.image_end && res.run_length == 8'd0)
        else $error("error beat malformed");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res.overrun_error |-> res.run_length != 8'd0)
        else $error("pixel beat with zero run");

    a_no_beat_on_header: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && expect_header_reg && (cfg.relax || !hdr_over) |=> expect_header_reg == 1'b0
            || $past(cfg.restart))
        else $error("accepted header did not open a packet");
`endif

endmodule

`default_nettype wire

// File: hdl/tgarle_out_reg.sv
// Result register of the TGA RLE decoder, drives the m_ channel.
// Depends on tgarle_pkg.
`default_nettype none

module tgarle_out_reg (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 res_valid,
    input  wire tgarle_pkg::result_t  res,
    output logic                      advance,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output tgarle_pkg::result_t       m_res
);

    logic                valid_reg, valid_next;
    tgarle_pkg::result_t res_reg;

    assign advance = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

`default_nettype wire

// File: hdl/tga_rle_packet_decoder_top.sv
// TGA run-length packet decoder, usage notes:
// s_ channel: one compressed stream byte per beat (packet header or pixel byte).
// m_ channel: one beat per completed pixel (run_length 1 for raw, packet length
//   for repeat) or one error beat in strict mode when a packet overruns the image.
// cfg channel: index 0 bytes_per_pixel, 1 pixel_count, 2 relax_mode; cfg_ready is
//   always high. Writing pixel_count restarts the image. Write only when idle.
// Data path: an accepted byte waits in the input register and is decoded from there;
//   its beat is captured by the result register. Throughput: one byte per cycle
//   unless m_ready stalls the m_ channel. The input register feeds the decode logic
//   and the result register in one pass; the only loop is the packet state update.
// Stall: while m_ready is low with a beat held, the input register holds one
//   more byte; s_ready then drops until the result register drains.
// Reset (aresetn low, synchronous): 3 bytes per pixel, pixel count 1, relax mode,
//   expecting a header, both registers empty.
// Depends on tgarle_pkg, tgarle_cfg_regs, tgarle_decode_core, tgarle_out_reg.
`default_nettype none

module tga_rle_packet_decoder_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [tgarle_pkg::BYTE_W-1:0]  s_packet_byte,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [tgarle_pkg::PIXEL_W-1:0]      m_pixel_value,
    output logic [7:0]                          m_run_length,
    output logic                                m_image_end,
    output logic                                m_overrun_error,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tgarle_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    tgarle_pkg::cfg_t    cfg;
    tgarle_pkg::result_t res;
    tgarle_pkg::result_t m_res;
    logic                res_valid;
    logic                advance;

    tgarle_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tgarle_decode_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_packet_byte (s_packet_byte),
        .cfg           (cfg),
        .advance       (advance),
        .res_valid     (res_valid),
        .res           (res)
    );

    tgarle_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_pixel_value   = m_res.pixel_value;
    assign m_run_length    = m_res.run_length;
    assign m_image_end     = m_res.image_end;
    assign m_overrun_error = m_res.overrun_error;

endmodule

`default_nettype wire

// File: tb/tb_tga_rle_packet_decoder_top.sv
// Self-checking testbench for tga_rle_packet_decoder_top: drives compressed stream bytes
// and register writes, predicts every run beat and checks them in order.
// Depends on tgarle_pkg and the decoder RTL; needs no files or arguments.
module tb_tga_rle_packet_decoder_top;

    localparam logic [tgarle_pkg::IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 4000;

    logic                               aclk            = 1'b0;
    logic                               aresetn         = 1'b0;
    logic                               s_valid         = 1'b0;
    logic                               s_ready;
    logic [tgarle_pkg::BYTE_W-1:0]      s_packet_byte   = '0;
    logic                               m_valid;
    logic                               m_ready         = 1'b0;
    logic [tgarle_pkg::PIXEL_W-1:0]     m_pixel_value;
    logic [7:0]                         m_run_length;
    logic                               m_image_end;
    logic                               m_overrun_error;
    logic                               cfg_valid       = 1'b0;
    logic                               cfg_ready;
    logic [tgarle_pkg::IDX_W-1:0]       cfg_index       = '0;
    logic [31:0]                        cfg_data        = '0;

    tga_rle_packet_decoder_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_packet_byte   (s_packet_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_value   (m_pixel_value),
        .m_run_length    (m_run_length),
        .m_image_end     (m_image_end),
        .m_overrun_error (m_overrun_error),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Decoder shadow: registers and packet state
    logic [tgarle_pkg::BPP_W-1:0]   bpp_q;
    logic [tgarle_pkg::COUNT_W-1:0] count_q;
    logic                           relax_q;
    logic                           hdr_wait;
    logic                           rep_pkt;
    logic [1:0]                     byte_pos;
    logic [7:0]                     pkt_left;
    logic [tgarle_pkg::PIXEL_W-1:0] assembly;
    logic [tgarle_pkg::COUNT_W-1:0] pix_left;

    tgarle_pkg::result_t pending_runs[$];

    bit idle_en      = 1'b1;
    int stall_left   = 0;
    int fail_count   = 0;
    int bytes_sent   = 0;
    int writes_done  = 0;
    int runs_checked = 0;
    int images_done  = 0;
    int overruns     = 0;

    function automatic void restart_image();
        hdr_wait = 1'b1;
        rep_pkt  = 1'b0;
        byte_pos = '0;
        pkt_left = '0;
        assembly = '0;
        pix_left = (count_q == '0) ? tgarle_pkg::COUNT_MIN : count_q;
    endfunction

    function automatic void apply_reg(logic [tgarle_pkg::IDX_W-1:0] idx, logic [31:0] d);
        case (idx)
            tgarle_pkg::CFG_BPP: begin
                bpp_q = d[tgarle_pkg::BPP_W-1:0];
            end
            tgarle_pkg::CFG_COUNT: begin
                count_q = d;
                restart_image();
            end
            tgarle_pkg::CFG_RELAX: begin
                relax_q = d[0];
            end
            default: ;
        endcase
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        int unsigned         len;
        int unsigned         width;
        logic                rep;
        logic [7:0]          run;
        tgarle_pkg::result_t r;
        if (hdr_wait) begin
            rep = b[7];
            len = rep ? 32'(b) - 32'(tgarle_pkg::REPEAT_BIAS) : 32'(b) + 32'd1;
            if (len > pix_left) begin
                if (!relax_q) begin
                    restart_image();
                    r.pixel_value   = '0;
                    r.run_length    = '0;
                    r.image_end     = 1'b1;
                    r.overrun_error = 1'b1;
                    pending_runs.push_back(r);
                    return;
                end
                len = pix_left;
            end
            hdr_wait = 1'b0;
            rep_pkt  = rep;
            pkt_left = len[7:0];
            byte_pos = '0;
            assembly = '0;
            return;
        end
        assembly = assembly | (32'(b) << (8 * int'(byte_pos)));
        if (bpp_q == '0)
            width = 32'(tgarle_pkg::BPP_MIN);
        else if (bpp_q > tgarle_pkg::BPP_MAX)
            width = 32'(tgarle_pkg::BPP_MAX);
        else
            width = 32'(bpp_q);
        if (32'(byte_pos) + 32'd1 < width) begin
            byte_pos = byte_pos + 2'd1;
            return;
        end
        run      = rep_pkt ? pkt_left : 8'd1;
        pix_left = (pix_left >= 32'(run)) ? pix_left - 32'(run) : '0;
        pkt_left = (pkt_left >= run) ? pkt_left - run : '0;
        r.pixel_value   = assembly;
        r.run_length    = run;
        r.image_end     = (pix_left == '0);
        r.overrun_error = 1'b0;
        byte_pos = '0;
        assembly = '0;
        if (pix_left == '0) begin
            restart_image();
        end else if (pkt_left == '0) begin
            hdr_wait = 1'b1;
            rep_pkt  = 1'b0;
        end
        pending_runs.push_back(r);
    endfunction

    // Mostly packets that fit the image; some arbitrary headers to hit overruns
    function automatic logic [7:0] pick_byte();
        int unsigned room;
        int unsigned len;
        if (!hdr_wait) begin
            if ($urandom_range(0, 7) == 0)
                return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            return 8'($urandom());
        end
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom());
        room = (pix_left < 128) ? pix_left : 128;
        if ($urandom_range(0, 3) == 0)
            len = room;
        else
            len = $urandom_range(1, (room < 8) ? room : 8);
        if ($urandom_range(0, 1))
            return 8'(len + tgarle_pkg::REPEAT_BIAS);
        return 8'(len - 1);
    endfunction

    task automatic flag_error(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic send_byte(logic [7:0] b);
        @(negedge aclk);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_packet_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic write_reg(logic [tgarle_pkg::IDX_W-1:0] idx, logic [31:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, d);
        writes_done++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stop the stream, wait for every expected beat, then let the pipe empty
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_runs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_runs.size() != 0) begin
            flag_error($sformatf("%0d expected runs never arrived", pending_runs.size()));
            pending_runs.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        tgarle_pkg::result_t exp_run;
        tgarle_pkg::result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.pixel_value   = m_pixel_value;
            got.run_length    = m_run_length;
            got.image_end     = m_image_end;
            got.overrun_error = m_overrun_error;
            if (got.image_end)
                images_done++;
            if (got.overrun_error)
                overruns++;
            if (pending_runs.size() == 0) begin
                flag_error($sformatf("unexpected beat pix %h len %0d end %b ovr %b",
                    got.pixel_value, got.run_length, got.image_end, got.overrun_error));
            end else begin
                exp_run = pending_runs.pop_front();
                runs_checked++;
                if (got.pixel_value !== exp_run.pixel_value ||
                    got.run_length !== exp_run.run_length ||
                    got.image_end !== exp_run.image_end ||
                    got.overrun_error !== exp_run.overrun_error)
                    flag_error($sformatf(
                        "run %0d: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                        runs_checked, exp_run.pixel_value, exp_run.run_length,
                        exp_run.image_end, exp_run.overrun_error, got.pixel_value,
                        got.run_length, got.image_end, got.overrun_error));
            end
        end
    end

    task automatic test_reset_defaults();
        // 3 bytes per pixel, one-pixel image, relaxed
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        settle();
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    endtask

    task automatic test_relaxed_clamp();
        settle();
        write_reg(tgarle_pkg::CFG_BPP, 32'd4);
        write_reg(tgarle_pkg::CFG_COUNT, 32'd3);
        write_reg(tgarle_pkg::CFG_RELAX, 32'd1);
        send_byte(8'hFF);
        repeat (4) send_byte(8'hFF);
        settle();
        write_reg(tgarle_pkg::CFG_BPP, 32'd1);
        write_reg(tgarle_pkg::CFG_COUNT, 32'd2);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_strict_overrun();
        settle();
        write_reg(tgarle_pkg::CFG_RELAX, 32'd0);
        write_reg(tgarle_pkg::CFG_BPP, 32'd2);
        write_reg(tgarle_pkg::CFG_COUNT, 32'd2);
        send_byte(8'h82);
        send_byte(8'h81);
        send_byte(8'h12);
        send_byte(8'h34);
    endtask

    task automatic test_width_aliases();
        settle();
        write_reg(tgarle_pkg::CFG_RELAX, 32'd1);
        write_reg(tgarle_pkg::CFG_BPP, 32'd0);
        write_reg(tgarle_pkg::CFG_COUNT, 32'd0);
        send_byte(8'h00);
        send_byte(8'h5A);
        settle();
        write_reg(tgarle_pkg::CFG_BPP, 32'd7);
        send_byte(8'h80);
        send_byte(8'hDE);
        send_byte(8'hAD);
        send_byte(8'hBE);
        send_byte(8'hEF);
    endtask

    task automatic test_midstream_writes();
        settle();
        write_reg(tgarle_pkg::CFG_BPP, 32'd4);
        write_reg(tgarle_pkg::CFG_COUNT, 32'd10);
        send_byte(8'h00);
        send_byte(8'h11);
        send_byte(8'h22);
        settle();
        // narrower width completes the half-built pixel
        write_reg(tgarle_pkg::CFG_BPP, 32'd2);
        send_byte(8'h33);
        send_byte(8'h85);
        settle();
        // count write drops the open repeat packet
        write_reg(tgarle_pkg::CFG_COUNT, 32'd5);
        send_byte(8'h01);
        send_byte(8'h44);
        send_byte(8'h55);
    endtask

    task automatic test_random_stream(int phases, int per_phase);
        logic [31:0] count_v;
        logic [2:0]  bpp_v;
        for (int p = 0; p < phases; p++) begin
            settle();
            case (p)
                0:       count_v = 32'hFFFE_0001;
                1:       count_v = 32'hFFFF_FFFF;
                2:       count_v = 32'd1;
                default: count_v = ($urandom_range(0, 2) == 0) ? $urandom_range(41, 400)
                                                               : $urandom_range(1, 40);
            endcase
            if ($urandom_range(0, 3) == 0)
                bpp_v = 3'($urandom_range(0, 7));
            else
                bpp_v = 3'($urandom_range(1, 4));
            write_reg(tgarle_pkg::CFG_BPP, ($urandom() & ~32'h7) | 32'(bpp_v));
            write_reg(tgarle_pkg::CFG_RELAX,
                ($urandom() & ~32'h1) | 32'($urandom_range(0, 1)));
            write_reg(tgarle_pkg::CFG_COUNT, count_v);
            for (int j = 0; j < per_phase; j++) begin
                send_byte(pick_byte());
                if (j == per_phase / 2 || $urandom_range(0, 299) == 0)
                    settle();
            end
        end
    endtask

    task automatic test_steady_stream(int count);
        settle();
        idle_en = 1'b0;
        write_reg(tgarle_pkg::CFG_BPP, 32'd3);
        write_reg(tgarle_pkg::CFG_RELAX, 32'd0);
        write_reg(tgarle_pkg::CFG_COUNT, 32'd50);
        repeat (count) send_byte(pick_byte());
    endtask

    initial begin
        bpp_q   = tgarle_pkg::BPP_RESET;
        count_q = tgarle_pkg::COUNT_RESET;
        relax_q = tgarle_pkg::RELAX_RESET;
        restart_image();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_relaxed_clamp();
        test_strict_overrun();
        test_width_aliases();
        test_midstream_writes();
        test_random_stream(9, 200);
        test_steady_stream(200);
        settle();

        $display("Run covered %0d stream bytes and %0d register writes.",
            bytes_sent, writes_done);
        $display("Checked %0d runs, %0d image ends, %0d overrun flags.",
            runs_checked, images_done, overruns);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures", fail_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
